// ===== design/dmwb_pkg.sv =====
// Package: geometry constants, state and line status types of the write-back cache.
package dmwb_pkg;

    localparam int LINE_BYTES     = 32;
    localparam int NUM_SETS       = 16;
    localparam int ADDR_BITS      = 12;

    localparam int DWORD_BYTES    = 8;
    localparam int BYTE_BITS      = $clog2(DWORD_BYTES);
    localparam int WORDS_PER_LINE = LINE_BYTES / DWORD_BYTES;
    localparam int WORD_BITS      = $clog2(WORDS_PER_LINE);
    localparam int SET_BITS       = $clog2(NUM_SETS);
    localparam int TAG_BITS       = ADDR_BITS - BYTE_BITS - WORD_BITS - SET_BITS;
    localparam int CNT_BITS       = WORD_BITS + 1;

    localparam int CACHE_WORDS    = NUM_SETS * WORDS_PER_LINE;
    localparam int CACHE_AW       = SET_BITS + WORD_BITS;
    localparam int MEM_AW         = ADDR_BITS - BYTE_BITS;
    localparam int MEM_WORDS      = 1 << MEM_AW;
    localparam int MEM_LINE_BITS  = TAG_BITS + SET_BITS;
    localparam int MEM_LINES      = 1 << MEM_LINE_BITS;

    localparam int DATA_BITS      = 64;

    typedef logic [DATA_BITS-1:0] dword_t;

    typedef enum logic [1:0] {
        LINE_INVALID = 2'd0,
        LINE_CLEAN   = 2'd1,
        LINE_DIRTY   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_HIT_READ,
        ST_WRITEBACK,
        ST_FILL,
        ST_DONE
    } state_t;

endpackage

// ===== design/dmwb_channels.sv =====
// Interfaces: request and response channels of the write-back cache.
interface dmwb_req_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [dmwb_pkg::ADDR_BITS-1:0]      address;
    dmwb_pkg::dword_t                    write_data;

    modport source (output valid, output mode, output address, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input address, input write_data,
                    output ready);
endinterface

interface dmwb_rsp_if;
    logic                                valid;
    logic                                ready;
    dmwb_pkg::dword_t                    read_data;
    logic                                hit;
    logic                                wrote_back;

    modport source (output valid, output read_data, output hit, output wrote_back,
                    input ready);
    modport sink   (input valid, input read_data, input hit, input wrote_back,
                    output ready);
endinterface

// ===== design/dmwb_ram.sv =====
// Generic single-port RAM with registered read data.
module dmwb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/direct_mapped_writeback_cache.sv =====
// Top level: direct-mapped write-back write-allocate cache with its backing memory.
//
// Each request word reads or writes one 64-bit dword; the low three address bits are
// dropped. One request is in service at a time, and a finished response waits in an
// output register while the next request is taken. After acceptance a write hit goes
// through lookup and done, a read hit through lookup, hit read and done, a clean miss
// through lookup, fill and done, and a dirty miss through lookup, write-back, fill and
// done. The block is back in idle as the response turns valid. A miss moves the line
// one dword per cycle through the single port of the line data RAM and of the backing
// RAM (4 dwords per line). A response held by the receiver stalls the block in its
// last state until the output register is free.
// Tags and line status sit in flip-flops; line data and backing memory are RAMs. The
// backing memory reads as zero after reset through one valid bit per memory line, so
// there is no clearing pass and requests are taken right after reset.
module direct_mapped_writeback_cache (
    input  logic          clk,
    input  logic          rst_n,
    dmwb_req_if.sink      req,
    dmwb_rsp_if.source    rsp
);

    localparam logic [dmwb_pkg::CNT_BITS-1:0] CNT_LAST =
        dmwb_pkg::CNT_BITS'(dmwb_pkg::WORDS_PER_LINE);

    dmwb_pkg::state_t state_reg, state_next;
    logic [dmwb_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;

    logic                           mode_reg;
    logic [dmwb_pkg::TAG_BITS-1:0]  tag_reg;
    logic [dmwb_pkg::SET_BITS-1:0]  set_reg;
    logic [dmwb_pkg::WORD_BITS-1:0] off_reg;
    dmwb_pkg::dword_t               wdata_reg;

    dmwb_pkg::dword_t               result_reg, result_next;
    logic                           hit_reg, hit_next;
    logic                           wb_reg, wb_next;

    logic [dmwb_pkg::TAG_BITS-1:0]  line_tag_reg [dmwb_pkg::NUM_SETS];
    dmwb_pkg::status_t              line_status_reg [dmwb_pkg::NUM_SETS];
    logic [dmwb_pkg::MEM_LINES-1:0] mem_valid_reg;

    logic                           out_valid_reg;
    dmwb_pkg::dword_t               out_data_reg;
    logic                           out_hit_reg;
    logic                           out_wb_reg;

    logic                           cache_we;
    logic [dmwb_pkg::CACHE_AW-1:0]  cache_addr;
    dmwb_pkg::dword_t               cache_wdata;
    dmwb_pkg::dword_t               cache_rdata;
    logic                           mem_we;
    logic [dmwb_pkg::MEM_AW-1:0]    mem_addr;
    dmwb_pkg::dword_t               mem_wdata;
    dmwb_pkg::dword_t               mem_rdata;

    logic                           tag_we;
    logic                           status_we;
    dmwb_pkg::status_t              status_val;
    logic                           mem_valid_set;
    logic                           load_out;

    logic                           accept;
    logic [dmwb_pkg::TAG_BITS-1:0]  old_tag;
    dmwb_pkg::status_t              cur_status;
    logic                           line_valid;
    logic                           line_dirty;
    logic                           lookup_hit;
    logic [dmwb_pkg::WORD_BITS-1:0] cnt_lo;
    logic [dmwb_pkg::WORD_BITS-1:0] cnt_prev;
    dmwb_pkg::dword_t               fill_word;

    dmwb_ram #(
        .WIDTH (dmwb_pkg::DATA_BITS),
        .DEPTH (dmwb_pkg::CACHE_WORDS)
    ) u_line_ram (
        .clk   (clk),
        .we    (cache_we),
        .addr  (cache_addr),
        .wdata (cache_wdata),
        .rdata (cache_rdata)
    );

    dmwb_ram #(
        .WIDTH (dmwb_pkg::DATA_BITS),
        .DEPTH (dmwb_pkg::MEM_WORDS)
    ) u_backing_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign req.ready = (state_reg == dmwb_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign old_tag    = line_tag_reg[set_reg];
    assign cur_status = line_status_reg[set_reg];
    assign line_valid = (cur_status != dmwb_pkg::LINE_INVALID);
    // status code 3 never occurs; treat it as dirty
    assign line_dirty = line_valid && (cur_status != dmwb_pkg::LINE_CLEAN);
    assign lookup_hit = line_valid && (old_tag == tag_reg);

    assign cnt_lo    = cnt_reg[dmwb_pkg::WORD_BITS-1:0];
    assign cnt_prev  = cnt_lo - dmwb_pkg::WORD_BITS'(1);
    assign fill_word = mem_valid_reg[{tag_reg, set_reg}] ? mem_rdata : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmwb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        result_next   = result_reg;
        hit_next      = hit_reg;
        wb_next       = wb_reg;
        cache_we      = 1'b0;
        cache_addr    = {set_reg, off_reg};
        cache_wdata   = wdata_reg;
        mem_we        = 1'b0;
        mem_addr      = {tag_reg, set_reg, cnt_lo};
        mem_wdata     = cache_rdata;
        tag_we        = 1'b0;
        status_we     = 1'b0;
        status_val    = dmwb_pkg::LINE_CLEAN;
        mem_valid_set = 1'b0;
        load_out      = 1'b0;

        case (state_reg)
            dmwb_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = dmwb_pkg::ST_LOOKUP;
                end
            end
            dmwb_pkg::ST_LOOKUP:
            begin
                hit_next    = lookup_hit;
                wb_next     = !lookup_hit && line_dirty;
                result_next = '0;
                cnt_next    = '0;
                if (lookup_hit)
                begin
                    if (mode_reg)
                    begin
                        cache_we   = 1'b1;
                        status_we  = 1'b1;
                        status_val = dmwb_pkg::LINE_DIRTY;
                        state_next = dmwb_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = dmwb_pkg::ST_HIT_READ;
                    end
                end
                else if (line_dirty)
                begin
                    state_next = dmwb_pkg::ST_WRITEBACK;
                end
                else
                begin
                    state_next = dmwb_pkg::ST_FILL;
                end
            end
            dmwb_pkg::ST_HIT_READ:
            begin
                result_next = cache_rdata;
                state_next  = dmwb_pkg::ST_DONE;
            end
            dmwb_pkg::ST_WRITEBACK:
            begin
                // read line dword n while storing dword n-1 to memory
                cache_addr = {set_reg, cnt_lo};
                mem_addr   = {old_tag, set_reg, cnt_prev};
                mem_we     = (cnt_reg != '0);
                if (cnt_reg == CNT_LAST)
                begin
                    mem_valid_set = 1'b1;
                    cnt_next      = '0;
                    state_next    = dmwb_pkg::ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + dmwb_pkg::CNT_BITS'(1);
                end
            end
            dmwb_pkg::ST_FILL:
            begin
                // fetch memory dword n while writing dword n-1 into the line
                mem_addr   = {tag_reg, set_reg, cnt_lo};
                cache_addr = {set_reg, cnt_prev};
                cache_we   = (cnt_reg != '0);
                if (mode_reg && (cnt_prev == off_reg))
                begin
                    cache_wdata = wdata_reg;
                end
                else
                begin
                    cache_wdata = fill_word;
                end
                if ((cnt_reg != '0) && !mode_reg && (cnt_prev == off_reg))
                begin
                    result_next = fill_word;
                end
                if (cnt_reg == CNT_LAST)
                begin
                    tag_we     = 1'b1;
                    status_we  = 1'b1;
                    status_val = mode_reg ? dmwb_pkg::LINE_DIRTY : dmwb_pkg::LINE_CLEAN;
                    state_next = dmwb_pkg::ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + dmwb_pkg::CNT_BITS'(1);
                end
            end
            dmwb_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = dmwb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dmwb_pkg::ST_IDLE;
            end
        endcase
    end

    // request fields and per-item working values
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= req.mode;
            off_reg   <= req.address[dmwb_pkg::BYTE_BITS +: dmwb_pkg::WORD_BITS];
            set_reg   <= req.address[dmwb_pkg::BYTE_BITS + dmwb_pkg::WORD_BITS +:
                                     dmwb_pkg::SET_BITS];
            tag_reg   <= req.address[dmwb_pkg::ADDR_BITS-1 -: dmwb_pkg::TAG_BITS];
            wdata_reg <= req.write_data;
        end
        result_reg <= result_next;
        hit_reg    <= hit_next;
        wb_reg     <= wb_next;
        if (load_out)
        begin
            out_data_reg <= result_reg;
            out_hit_reg  <= hit_reg;
            out_wb_reg   <= wb_reg;
        end
        if (tag_we)
        begin
            line_tag_reg[set_reg] <= tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            mem_valid_reg <= '0;
            for (int i = 0; i < dmwb_pkg::NUM_SETS; i++)
            begin
                line_status_reg[i] <= dmwb_pkg::LINE_INVALID;
            end
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mem_valid_set)
            begin
                mem_valid_reg[{old_tag, set_reg}] <= 1'b1;
            end
            if (status_we)
            begin
                line_status_reg[set_reg] <= status_val;
            end
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = out_data_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.wrote_back = out_wb_reg;

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == dmwb_pkg::ST_LOOKUP))
        else $error("accepted word did not enter lookup");

    a_hit_no_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_wb_reg))
        else $error("hit reported together with writeback");

    a_single_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cache_we && mem_we))
        else $error("line RAM and backing RAM written in the same cycle");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_LAST)
        else $error("line dword counter out of range");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || rsp.ready))
        else $error("response overwritten before it was taken");

endmodule

// ===== tb/tb_direct_mapped_writeback_cache.sv =====
// Testbench: random and directed cache accesses checked against a behavioral cache model.
module tb_direct_mapped_writeback_cache;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam int RANDOM_PER_PHASE = 325;
    localparam int HOLD_CYCLES      = 200;
    localparam int DRAIN_CYCLES     = 20;
    localparam int STALL_LIMIT      = 2000;

    typedef struct packed {
        logic                           mode;
        logic [dmwb_pkg::ADDR_BITS-1:0] address;
        dmwb_pkg::dword_t               write_data;
    } cache_access_t;

    typedef struct packed {
        dmwb_pkg::dword_t read_data;
        logic             hit;
        logic             wrote_back;
    } cache_result_t;

    logic clk = 1'b0;
    logic rst_n;

    dmwb_req_if req ();
    dmwb_rsp_if rsp ();

    direct_mapped_writeback_cache u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #5 clk = ~clk;

    // Shadow of the cache and its backing memory
    logic [dmwb_pkg::TAG_BITS-1:0] shadow_tag [dmwb_pkg::NUM_SETS];
    dmwb_pkg::status_t             shadow_status [dmwb_pkg::NUM_SETS];
    dmwb_pkg::dword_t              shadow_line [dmwb_pkg::CACHE_WORDS];
    dmwb_pkg::dword_t              shadow_mem [dmwb_pkg::MEM_WORDS];

    cache_access_t pending_accesses[$];
    cache_result_t expected_results[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holds_asked    = 0;
    int holds_done     = 0;
    int hold_left      = 0;
    int err_count      = 0;
    int stall_count    = 0;

    logic [dmwb_pkg::TAG_BITS-1:0] hot_tag_a;
    logic [dmwb_pkg::TAG_BITS-1:0] hot_tag_b;

    function automatic cache_result_t cache_access(input cache_access_t acc);
        cache_result_t                   res;
        logic [dmwb_pkg::WORD_BITS-1:0]  word;
        logic [dmwb_pkg::SET_BITS-1:0]   set_idx;
        logic [dmwb_pkg::TAG_BITS-1:0]   tag;
        logic                            valid;
        logic [dmwb_pkg::CACHE_AW-1:0]   slot;
        logic [dmwb_pkg::MEM_AW-1:0]     mem_base;
        word    = acc.address[dmwb_pkg::BYTE_BITS +: dmwb_pkg::WORD_BITS];
        set_idx = acc.address[dmwb_pkg::BYTE_BITS + dmwb_pkg::WORD_BITS +: dmwb_pkg::SET_BITS];
        tag     = acc.address[dmwb_pkg::ADDR_BITS-1 -: dmwb_pkg::TAG_BITS];
        valid   = shadow_status[set_idx] != dmwb_pkg::LINE_INVALID;
        res.hit = valid && shadow_tag[set_idx] == tag;
        res.wrote_back = 1'b0;
        if (!res.hit)
        begin
            // anything valid that is not clean goes back to memory
            if (valid && shadow_status[set_idx] != dmwb_pkg::LINE_CLEAN)
            begin
                mem_base = {shadow_tag[set_idx], set_idx, {dmwb_pkg::WORD_BITS{1'b0}}};
                for (int i = 0; i < dmwb_pkg::WORDS_PER_LINE; i++)
                    shadow_mem[mem_base + dmwb_pkg::MEM_AW'(i)] =
                        shadow_line[{set_idx, dmwb_pkg::WORD_BITS'(i)}];
                res.wrote_back = 1'b1;
            end
            mem_base = {tag, set_idx, {dmwb_pkg::WORD_BITS{1'b0}}};
            for (int i = 0; i < dmwb_pkg::WORDS_PER_LINE; i++)
                shadow_line[{set_idx, dmwb_pkg::WORD_BITS'(i)}] =
                    shadow_mem[mem_base + dmwb_pkg::MEM_AW'(i)];
            shadow_tag[set_idx]    = tag;
            shadow_status[set_idx] = dmwb_pkg::LINE_CLEAN;
        end
        slot = {set_idx, word};
        if (acc.mode == MODE_WRITE)
        begin
            shadow_line[slot]      = acc.write_data;
            shadow_status[set_idx] = dmwb_pkg::LINE_DIRTY;
            res.read_data          = '0;
        end
        else
        begin
            res.read_data = shadow_line[slot];
        end
        return res;
    endfunction

    function automatic cache_access_t random_access();
        cache_access_t acc;
        acc.mode       = 1'($urandom_range(1));
        acc.address    = dmwb_pkg::ADDR_BITS'($urandom_range(2**dmwb_pkg::ADDR_BITS - 1));
        acc.write_data = {$urandom, $urandom};
        // keep most traffic on two tags so hits and dirty evictions are common
        if ($urandom_range(99) < 70)
            acc.address[dmwb_pkg::ADDR_BITS-1 -: dmwb_pkg::TAG_BITS] =
                $urandom_range(1) ? hot_tag_a : hot_tag_b;
        case ($urandom_range(19))
            0: acc.write_data = '0;
            1: acc.write_data = '1;
            default: ;
        endcase
        return acc;
    endfunction

    task automatic push_access(input logic mode,
                               input logic [dmwb_pkg::ADDR_BITS-1:0] address,
                               input dmwb_pkg::dword_t data);
        cache_access_t acc;
        acc.mode       = mode;
        acc.address    = address;
        acc.write_data = data;
        pending_accesses.push_back(acc);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_accesses.size() != 0 || req.valid || expected_results.size() != 0);
    endtask

    // Request driver
    always @(posedge clk)
    begin : drive_req
        cache_access_t nxt;
        if (rst_n)
        begin
            if (!req.valid || req.ready)
            begin
                if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_accesses.pop_front();
                    req.valid      <= 1'b1;
                    req.mode       <= nxt.mode;
                    req.address    <= nxt.address;
                    req.write_data <= nxt.write_data;
                end
                else
                begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // Response ready, with long hold-offs on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                rsp.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else if (holds_done != holds_asked)
            begin
                holds_done = holds_done + 1;
                hold_left  = HOLD_CYCLES;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Monitor: check responses, then predict newly accepted words
    always @(posedge clk)
    begin : monitor
        cache_result_t want;
        cache_access_t acc;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected response: read_data=%h hit=%b wrote_back=%b",
                           rsp.read_data, rsp.hit, rsp.wrote_back);
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, got %h", want.read_data, rsp.read_data);
                        err_count++;
                    end
                    if (rsp.hit !== want.hit)
                    begin
                        $error("hit: expected %b, got %b", want.hit, rsp.hit);
                        err_count++;
                    end
                    if (rsp.wrote_back !== want.wrote_back)
                    begin
                        $error("wrote_back: expected %b, got %b", want.wrote_back,
                               rsp.wrote_back);
                        err_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                acc.mode       = req.mode;
                acc.address    = req.address;
                acc.write_data = req.write_data;
                expected_results.push_back(cache_access(acc));
            end
        end
    end

    // Watchdog on cycles without any accepted word or taken response
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                stall_count = 0;
            else
                stall_count = stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.mode       = MODE_READ;
        req.address    = '0;
        req.write_data = '0;
        rsp.ready      = 1'b0;
        for (int i = 0; i < dmwb_pkg::NUM_SETS; i++)
        begin
            shadow_tag[i]    = '0;
            shadow_status[i] = dmwb_pkg::LINE_INVALID;
        end
        for (int i = 0; i < dmwb_pkg::MEM_WORDS; i++)
            shadow_mem[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // cold miss, write hit, unaligned read hit
        push_access(MODE_READ,  12'h000, 64'h0);
        push_access(MODE_WRITE, 12'h000, '1);
        push_access(MODE_READ,  12'h007, 64'h0);
        push_access(MODE_WRITE, 12'h018, 64'h0123_4567_89AB_CDEF);
        // dirty eviction, then refill of the evicted line from memory
        push_access(MODE_READ,  12'h200, '1);
        push_access(MODE_READ,  12'h000, '1);
        push_access(MODE_READ,  12'h01F, 64'h0);
        // top of the address space, unaligned write
        push_access(MODE_WRITE, 12'hFF8, 64'h0);
        push_access(MODE_WRITE, 12'hFFF, '1);
        push_access(MODE_READ,  12'hFF8, 64'h0);
        push_access(MODE_WRITE, 12'h1F8, 64'hA5A5_A5A5_A5A5_A5A5);
        push_access(MODE_READ,  12'hFF0, 64'h0);
        push_access(MODE_READ,  12'hFFF, 64'h0);
        push_access(MODE_WRITE, 12'h800, 64'h5A5A_5A5A_5A5A_5A5A);
        push_access(MODE_READ,  12'h1FF, 64'h0);
        push_access(MODE_READ,  12'h800, 64'h0);
        push_access(MODE_WRITE, 12'h000, 64'h8000_0000_0000_0001);
        push_access(MODE_READ,  12'h200, 64'h0);
        push_access(MODE_READ,  12'h000, 64'h0);
        wait_idle();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 55; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct = 27; recv_stall_pct = 27;
                end
            endcase
            hot_tag_a = dmwb_pkg::TAG_BITS'($urandom_range(2**dmwb_pkg::TAG_BITS - 1));
            hot_tag_b = dmwb_pkg::TAG_BITS'($urandom_range(2**dmwb_pkg::TAG_BITS - 1));
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                pending_accesses.push_back(random_access());
            // hold the response side off so the block fills and backs up
            if (phase == 0)
                holds_asked = holds_asked + 1;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dmwb_pkg.sv
design/dmwb_channels.sv
design/dmwb_ram.sv
design/direct_mapped_writeback_cache.sv
tb/tb_direct_mapped_writeback_cache.sv
